// ----- rtl/core/linear_scan_key_value_table_unit_defines.svh -----
// Assertion helpers for the key/value table.
// Both expect i_clk and i_rst_n in scope.
`ifndef LINEAR_SCAN_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define LINEAR_SCAN_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define LSKVT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSKVT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lskvt_pkg.sv -----
package lskvt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int KB_W     = 4;
    localparam int SLOT_W   = 4;
    localparam int LIVE_W   = 5;

    localparam logic [KB_W-1:0] KB_RESET = KB_W'(8);

    // command queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [KEY_W-1:0]  mask;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SWAP
    } t_bk_state;

    // byte mask over the compared low key bytes; 0 acts as 1, 9..15 as 8
    function automatic logic [KEY_W-1:0] compare_mask(input logic [KB_W-1:0] kb);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (b == 0 || b < int'(kb)) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/lskvt_req_if.sv -----
interface lskvt_req_if import lskvt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;

    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

// ----- rtl/core/lskvt_rsp_if.sv -----
interface lskvt_rsp_if import lskvt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [VAL_W-1:0]  old_value;
    logic [SLOT_W-1:0] slot_index;
    logic [LIVE_W-1:0] live_count;
    logic              full_error;

    modport source (output valid, found, old_value, slot_index, live_count, full_error,
                    input ready);
    modport sink   (input valid, found, old_value, slot_index, live_count, full_error,
                    output ready);
endinterface

// ----- rtl/core/lskvt_ram.sv -----
module lskvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lskvt_front.sv -----
module lskvt_front import lskvt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [KB_W-1:0] i_key_bytes,
    lskvt_req_if.sink       i_req,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  logic            i_cmd_ready
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_take;

    // holding stage: refill while the staged command drains
    assign i_req.ready = !r_valid || i_cmd_ready;
    assign w_take      = i_req.valid && i_req.ready;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (r_valid && i_cmd_ready) begin
            n_valid = 1'b0;
        end
        if (w_take) begin
            n_valid     = 1'b1;
            n_cmd.kind  = t_kind'(i_req.kind);
            n_cmd.key   = i_req.key;
            n_cmd.value = i_req.value;
            n_cmd.mask  = compare_mask(i_key_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ----- rtl/core/lskvt_cmd_q.sv -----
module lskvt_cmd_q import lskvt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_cnt != QCNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- rtl/core/lskvt_back.sv -----
module lskvt_back import lskvt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    lskvt_rsp_if.source      o_rsp,
    output logic [CNT_W-1:0] o_count
);

    t_bk_state         r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    logic [VAL_W-1:0]  r_out_old, n_out_old;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [LIVE_W-1:0] r_out_live, n_out_live;
    logic              r_out_full, n_out_full;

    logic              w_kwe, w_vwe;
    logic [IDX_W-1:0]  w_waddr, w_raddr, w_last;
    logic [KEY_W-1:0]  w_kwdata, w_kdata;
    logic [VAL_W-1:0]  w_vwdata, w_vdata;
    logic              w_hit, w_at_last;

    lskvt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (w_waddr),
        .i_wdata (w_kwdata),
        .i_raddr (w_raddr),
        .o_rdata (w_kdata)
    );

    lskvt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_waddr),
        .i_wdata (w_vwdata),
        .i_raddr (w_raddr),
        .o_rdata (w_vdata)
    );

    assign w_last    = IDX_W'(r_count - CNT_W'(1));
    assign w_at_last = (r_idx == w_last);
    assign w_hit     = (((w_kdata ^ r_cmd.key) & r_cmd.mask) == '0);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_old   = r_out_old;
        n_out_slot  = r_out_slot;
        n_out_live  = r_out_live;
        n_out_full  = r_out_full;
        o_cmd_pop   = 1'b0;
        w_kwe       = 1'b0;
        w_vwe       = 1'b0;
        w_waddr     = r_idx;
        w_kwdata    = r_cmd.key;
        w_vwdata    = r_cmd.value;
        w_raddr     = r_idx + IDX_W'(1);

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_cmd       = i_cmd;
                    n_idx       = '0;
                    w_raddr     = '0;
                    n_out_found = 1'b0;
                    n_out_old   = '0;
                    n_out_slot  = '0;
                    n_out_full  = 1'b0;
                    if (i_cmd.kind == KIND_NOP || r_count == '0) begin
                        // nothing to scan; an insert lands in entry 0
                        if (i_cmd.kind == KIND_INSERT) begin
                            w_kwe    = 1'b1;
                            w_vwe    = 1'b1;
                            w_waddr  = '0;
                            w_kwdata = i_cmd.key;
                            w_vwdata = i_cmd.value;
                            n_count  = r_count + CNT_W'(1);
                        end
                        n_out_live  = LIVE_W'(n_count);
                        n_out_valid = 1'b1;
                    end else begin
                        n_state = BK_SCAN;
                    end
                end
            end

            BK_SCAN: begin
                if (w_hit) begin
                    n_out_found = 1'b1;
                    n_out_old   = w_vdata;
                    n_out_slot  = SLOT_W'(r_idx);
                    n_state     = BK_IDLE;
                    case (r_cmd.kind)
                        KIND_INSERT: begin
                            w_vwe = 1'b1;
                        end
                        KIND_REMOVE: begin
                            if (w_at_last) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                // fetch the last entry to fill the hole
                                w_raddr = w_last;
                                n_state = BK_SWAP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (n_state == BK_IDLE) begin
                        n_out_live  = LIVE_W'(n_count);
                        n_out_valid = 1'b1;
                    end
                end else if (w_at_last) begin
                    n_state = BK_IDLE;
                    if (r_cmd.kind == KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_out_full = 1'b1;
                        end else begin
                            w_kwe      = 1'b1;
                            w_vwe      = 1'b1;
                            w_waddr    = IDX_W'(r_count);
                            n_out_slot = SLOT_W'(r_count);
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    n_out_live  = LIVE_W'(n_count);
                    n_out_valid = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            BK_SWAP: begin
                w_kwe       = 1'b1;
                w_vwe       = 1'b1;
                w_kwdata    = w_kdata;
                w_vwdata    = w_vdata;
                n_count     = r_count - CNT_W'(1);
                n_out_live  = LIVE_W'(n_count);
                n_out_valid = 1'b1;
                n_state     = BK_IDLE;
            end

            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_out_found <= n_out_found;
        r_out_old  <= n_out_old;
        r_out_slot <= n_out_slot;
        r_out_live <= n_out_live;
        r_out_full <= n_out_full;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.old_value  = r_out_old;
    assign o_rsp.slot_index = r_out_slot;
    assign o_rsp.live_count = r_out_live;
    assign o_rsp.full_error = r_out_full;
    assign o_count          = r_count;

endmodule

// ----- rtl/core/linear_scan_key_value_table_unit.sv -----
// Key/value table of up to 16 entries with 64-bit keys and values, searched
// linearly from entry 0; the first entry whose low key_bytes bytes match wins.
// Each request transaction (kind: lookup, insert/replace, remove) yields exactly
// one response transaction carrying found, old_value, slot_index, live_count and
// full_error. An insert that misses on a full table is refused with full_error.
// A remove fills the hole with the last entry, so entry order is not kept.
// Requests pass through a one-entry staging register and a two-entry command
// queue; the execution engine works on one command at a time. A command has
// a start step, then one compare per entry (keys come out of a RAM with a
// registered read, one entry per cycle), then a swap step on a remove that
// does not hit the last entry. On a full table the longest commands include a
// miss over all 16 entries and a remove that hits entry 14. Any command on
// an empty table and the unused kind need no scan. The engine starts a new
// command only once the previous response has been taken. key_bytes is
// written through i_cfg_we/i_cfg_wdata and must only change while no
// transaction is in flight; stored entries need no clearing after reset.
`include "linear_scan_key_value_table_unit_defines.svh"

module linear_scan_key_value_table_unit import lskvt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [KB_W-1:0] i_cfg_wdata,
    lskvt_req_if.sink       i_req,
    lskvt_rsp_if.source     o_rsp
);

    logic [KB_W-1:0]  r_key_bytes;
    logic             w_stg_valid;
    t_cmd             w_stg_cmd;
    logic             w_q_ready;
    logic             w_q_valid;
    t_cmd             w_q_cmd;
    logic             w_q_pop;
    logic [CNT_W-1:0] w_count;

    // compare width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= KB_RESET;
        end else if (i_cfg_we) begin
            r_key_bytes <= i_cfg_wdata;
        end
    end

    // front: takes the transaction, decodes kind, builds the byte mask
    lskvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_bytes (r_key_bytes),
        .i_req       (i_req),
        .o_cmd_valid (w_stg_valid),
        .o_cmd       (w_stg_cmd),
        .i_cmd_ready (w_q_ready)
    );

    // decouples acceptance from the scan
    lskvt_cmd_q u_cmd_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_stg_valid),
        .i_push_cmd   (w_stg_cmd),
        .o_push_ready (w_q_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_cmd    (w_q_cmd),
        .i_pop        (w_q_pop)
    );

    // back: scan, write-back, swap-remove and response register
    lskvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_rsp       (o_rsp),
        .o_count     (w_count)
    );

    `LSKVT_ASSERT_IMP(a_live_bound, o_rsp.valid,
        o_rsp.live_count <= LIVE_W'(CAPACITY), "live count beyond capacity")
    `LSKVT_ASSERT_IMP(a_full_err, o_rsp.valid && o_rsp.full_error,
        !o_rsp.found && o_rsp.live_count == LIVE_W'(CAPACITY) && o_rsp.old_value == '0,
        "bad refused insert")
    `LSKVT_ASSERT_IMP(a_miss_zero, o_rsp.valid && !o_rsp.found,
        o_rsp.old_value == '0, "old value on a miss")
    `LSKVT_ASSERT_NXT(a_count_held, o_rsp.valid && o_rsp.ready,
        LIVE_W'(w_count) == $past(o_rsp.live_count), "count moved while response held")

endmodule

// ----- dv/linear_scan_key_value_table_unit_tb.sv -----
module linear_scan_key_value_table_unit_tb;
    import lskvt_pkg::*;

    // run shape
    localparam int unsigned CYCLE_LIMIT  = 400000; // watchdog, far above the slowest run
    localparam int          PHASES       = 8;
    localparam int          PHASE_OPS    = 140;
    localparam int          POOL_SIZE    = 24;     // more keys than entries, so the table fills
    localparam int          HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int          DRAIN_CYCLES = 40;     // > worst-case engine time per transaction
    localparam int          REPORT_MAX   = 10;

    // one response transaction, as the table should produce it
    typedef struct packed {
        logic              found;
        logic [VAL_W-1:0]  old_value;
        logic [SLOT_W-1:0] slot;
        logic [LIVE_W-1:0] live;
        logic              full;
    } op_outcome_t;

    // one row of request stimulus; want is used only when fixed is set
    typedef struct {
        t_kind             kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        bit                fixed;
        op_outcome_t       want;
    } stim_row_t;

    // receiver back-pressure styles
    typedef enum {RX_OPEN, RX_COIN, RX_PULSE, RX_STINGY} rx_mode_t;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [KB_W-1:0] i_cfg_wdata;

    lskvt_req_if req_if ();
    lskvt_rsp_if rsp_if ();

    linear_scan_key_value_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the table and its key width
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    logic [VAL_W-1:0] shadow_vals [CAPACITY];
    int               shadow_count = 0;
    logic [KB_W-1:0]  shadow_kb    = KB_RESET;

    // outcomes of accepted requests, oldest first
    op_outcome_t op_outcome_q [$];

    stim_row_t        directed_ops [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [KB_W-1:0]  phase_kb [PHASES] = '{4'd1, 4'd8, 4'd0, 4'd5, 4'd15, 4'd3, 4'd9, 4'd2};

    // sender / receiver idling controls
    bit       tx_gaps_on = 1'b1;
    int       burst_left = 0;
    bit       rx_free    = 1'b0;
    bit       hold_req   = 1'b0;
    int       hold_left  = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       mode_left  = 0;

    // bookkeeping
    int unsigned cycle_cnt = 0;
    int          mismatches = 0;
    int          n_checked  = 0;
    int          n_lookup = 0, n_insert = 0, n_remove = 0, n_nop = 0;
    int          n_hits = 0, n_refused = 0, n_widths = 0;

    op_outcome_t rsp_want, rsp_got;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // compare mask over the low key bytes; width 0 acts as 1, anything past 8 as 8
    function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
        int n;
        n = int'(kb);
        if (n == 0) n = 1;
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Applies one request to the shadow table and returns the response it must give.
    // First matching entry wins, so stale duplicates after a width change resolve low.
    function automatic op_outcome_t table_op_result(input t_kind kind,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] value);
        op_outcome_t      res;
        logic [KEY_W-1:0] m;
        int               hit;
        int               last;
        res = '0;
        m   = key_mask(shadow_kb);
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && ((shadow_keys[i] ^ key) & m) == '0) hit = i;
        end
        case (kind)
            KIND_LOOKUP: begin
                if (hit >= 0) begin
                    res.found     = 1'b1;
                    res.old_value = shadow_vals[hit];
                    res.slot      = SLOT_W'(hit);
                end
            end
            KIND_INSERT: begin
                if (hit >= 0) begin
                    // replace: stored key kept, old value handed back
                    res.found        = 1'b1;
                    res.old_value    = shadow_vals[hit];
                    res.slot         = SLOT_W'(hit);
                    shadow_vals[hit] = value;
                end else if (shadow_count >= CAPACITY) begin
                    res.full = 1'b1;
                end else begin
                    shadow_keys[shadow_count] = key;
                    shadow_vals[shadow_count] = value;
                    res.slot                  = SLOT_W'(shadow_count);
                    shadow_count++;
                end
            end
            KIND_REMOVE: begin
                if (hit >= 0) begin
                    last          = shadow_count - 1;
                    res.found     = 1'b1;
                    res.old_value = shadow_vals[hit];
                    res.slot      = SLOT_W'(hit);
                    // hole is filled by the last entry
                    if (hit != last) begin
                        shadow_keys[hit] = shadow_keys[last];
                        shadow_vals[hit] = shadow_vals[last];
                    end
                    shadow_count = last;
                end
            end
            default: ;
        endcase
        res.live = LIVE_W'(shadow_count);
        return res;
    endfunction

    function automatic void add_row(input t_kind kind, input logic [KEY_W-1:0] key,
                                    input logic [VAL_W-1:0] value, input bit fixed,
                                    input logic found, input logic [VAL_W-1:0] old_value,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic [LIVE_W-1:0] live, input logic full);
        stim_row_t row;
        row.kind  = kind;
        row.key   = key;
        row.value = value;
        row.fixed = fixed;
        row.want  = '{found, old_value, slot, live, full};
        directed_ops.push_back(row);
    endfunction

    // Key choice: mostly keys that are live or in the pool, so hits, replaces and
    // removes are common; pool variants differ only above some byte and so turn
    // into matches once the compared width drops.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int j;
        r = $urandom_range(0, 99);
        if (shadow_count > 0 && r < 45) return shadow_keys[$urandom_range(0, shadow_count - 1)];
        j = $urandom_range(0, POOL_SIZE - 1);
        if (r < 70) return key_pool[j];
        if (r < 88) return key_pool[j] ^ (rand64() << (8 * $urandom_range(1, 7)));
        return rand64();
    endfunction

    function automatic void report_mismatch(input string what, input op_outcome_t want,
                                            input op_outcome_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] %s", $realtime, what);
            $display("    want found=%0b old=%h slot=%0d live=%0d full=%0b",
                     want.found, want.old_value, want.slot, want.live, want.full);
            $display("    got  found=%0b old=%h slot=%0d live=%0d full=%0b",
                     got.found, got.old_value, got.slot, got.live, got.full);
        end
    endfunction

    // Sender idling: bursts of random length, then a gap. Valid is only lowered
    // here, at the step of the last acceptance, or in drain(), never in a step that raises it.
    task automatic sender_gap();
        int gap;
        if (!tx_gaps_on) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        burst_left = $urandom_range(0, 20);
    endtask

    // Offers one request transaction and holds it until accepted, then records
    // the response it must produce.
    task automatic send_op(input stim_row_t row);
        op_outcome_t pred;
        req_if.valid <= 1'b1;
        req_if.kind  <= row.kind;
        req_if.key   <= row.key;
        req_if.value <= row.value;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pred = table_op_result(row.kind, row.key, row.value);
        op_outcome_q.push_back(row.fixed ? row.want : pred);
        case (row.kind)
            KIND_LOOKUP: n_lookup++;
            KIND_INSERT: n_insert++;
            KIND_REMOVE: n_remove++;
            default:     n_nop++;
        endcase
        if (pred.found) n_hits++;
        if (pred.full)  n_refused++;
        sender_gap();
    endtask

    // sender pause until every outstanding response has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (op_outcome_q.size() != 0) @(posedge i_clk);
    endtask

    // key width write; only called with nothing in flight
    task automatic write_key_bytes(input logic [KB_W-1:0] kb);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kb;
        @(posedge i_clk);
        shadow_kb = kb;
        i_cfg_we  <= 1'b0;
        n_widths++;
    endtask

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_cnt, op_outcome_q.size());
        $display("Verification failed");
        $finish;
    end

    // Receiver: own stall pattern, switched now and then at random, plus an
    // on-request hold-off counted here so the table backs up into the sender.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (rx_free) begin
                rsp_if.ready <= 1'b1;
            end else begin
                case (rx_mode)
                    RX_OPEN:   rsp_if.ready <= 1'b1;
                    RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
                    RX_PULSE:  rsp_if.ready <= (cycle_cnt % 3 != 0);
                    default:   rsp_if.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Response checker: every accepted response transaction against the oldest
    // outstanding outcome, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            n_checked++;
            rsp_got.found     = rsp_if.found;
            rsp_got.old_value = rsp_if.old_value;
            rsp_got.slot      = rsp_if.slot_index;
            rsp_got.live      = rsp_if.live_count;
            rsp_got.full      = rsp_if.full_error;
            if (op_outcome_q.size() == 0) begin
                report_mismatch("response with no request outstanding", '0, rsp_got);
            end else begin
                rsp_want = op_outcome_q.pop_front();
                if (rsp_got.found !== rsp_want.found || rsp_got.old_value !== rsp_want.old_value ||
                    rsp_got.slot !== rsp_want.slot || rsp_got.live !== rsp_want.live ||
                    rsp_got.full !== rsp_want.full) begin
                    report_mismatch("response mismatch", rsp_want, rsp_got);
                end
            end
        end
    end

    initial begin
        stim_row_t        row;
        int               r;
        int               ins_pct;
        int               rem_pct;
        logic [KEY_W-1:0] ones;

        ones = '1;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        req_if.valid <= 1'b0;
        req_if.kind  <= KIND_LOOKUP;
        req_if.key   <= '0;
        req_if.value <= '0;

        foreach (key_pool[i]) key_pool[i] = rand64();

        // Directed rows, run at the reset key width (all 8 bytes).
        // Empty table: misses and the unused kind report only the count.
        add_row(KIND_LOOKUP, '0,   '0, 1, 0, '0, 0, 0, 0);
        add_row(KIND_REMOVE, ones, '0, 1, 0, '0, 0, 0, 0);
        add_row(KIND_NOP,    ones, ones, 1, 0, '0, 0, 0, 0);
        // extreme keys and values, append then replace
        add_row(KIND_INSERT, '0,   ones, 1, 0, '0, 0, 1, 0);
        add_row(KIND_INSERT, ones, '0,   1, 0, '0, 1, 2, 0);
        add_row(KIND_LOOKUP, '0,   '0,   1, 1, ones, 0, 2, 0);
        add_row(KIND_INSERT, ones, 64'h0123_4567_89AB_CDEF, 1, 1, '0, 1, 2, 0);
        // top byte differs: a miss at full width
        add_row(KIND_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, '0, 1, 0, '0, 0, 2, 0);
        // remove of entry 0 pulls the last entry down
        add_row(KIND_REMOVE, '0,   '0, 1, 1, ones, 0, 1, 0);
        add_row(KIND_LOOKUP, ones, '0, 1, 1, 64'h0123_4567_89AB_CDEF, 0, 1, 0);
        // fill to capacity
        for (int i = 0; i < CAPACITY - 1; i++) begin
            add_row(KIND_INSERT, {8{8'(i + 1)}}, rand64(), 0, 0, '0, 0, 0, 0);
        end
        // full table: a new key is refused, nothing changes
        add_row(KIND_INSERT, 64'h8000_0000_0000_0000, ones, 1, 0, '0, 0, 16, 1);
        add_row(KIND_NOP,    '0, '0, 1, 0, '0, 0, 16, 0);
        add_row(KIND_LOOKUP, {8{8'(CAPACITY - 1)}}, '0, 0, 0, '0, 0, 0, 0);
        add_row(KIND_REMOVE, ones, '0, 0, 0, '0, 0, 0, 0);
        add_row(KIND_REMOVE, {8{8'(CAPACITY - 1)}}, '0, 0, 0, '0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[i]) send_op(directed_ops[i]);

        // Random phases, each at its own key width. The table is never cleared
        // between them, so narrowing the width leaves stale duplicates behind.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_key_bytes(phase_kb[p]);
            tx_gaps_on = (p != 0 && p != 2);
            rx_free    = (p == 0);        // first phase: no idling on either side
            if (p == 2) hold_req = 1'b1;  // back the table up against a stalled receiver
            ins_pct = p[0] ? 30 : 45;
            rem_pct = p[0] ? 35 : 20;
            for (int n = 0; n < PHASE_OPS; n++) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)                row.kind = KIND_INSERT;
                else if (r < ins_pct + rem_pct) row.kind = KIND_REMOVE;
                else if (r < 95)                row.kind = KIND_LOOKUP;
                else                            row.kind = KIND_NOP;
                row.key   = pick_key();
                row.value = rand64();
                row.fixed = 1'b0;
                row.want  = '0;
                send_op(row);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d lookups, %0d inserts, %0d removes, %0d no-ops over %0d key widths",
                 n_lookup, n_insert, n_remove, n_nop, n_widths);
        $display("%0d hits, %0d refused inserts; %0d responses checked, %0d wrong",
                 n_hits, n_refused, n_checked, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lskvt_pkg.sv
rtl/core/lskvt_req_if.sv
rtl/core/lskvt_rsp_if.sv
rtl/core/lskvt_ram.sv
rtl/core/lskvt_front.sv
rtl/core/lskvt_cmd_q.sv
rtl/core/lskvt_back.sv
rtl/core/linear_scan_key_value_table_unit.sv
dv/linear_scan_key_value_table_unit_tb.sv
